// ===== src/acm_pkg.sv =====
`default_nettype none

package acm_pkg;

    // Number format: signed fixed point, FRAC_BITS fraction bits in WORD_BITS words
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Matrix shape: three rows of four columns, three terms per column
    localparam int NUM_ROWS    = 3;
    localparam int NUM_COLS    = 4;
    localparam int NUM_TERMS   = 3;
    localparam int STORE_DEPTH = NUM_ROWS * NUM_COLS;
    localparam int TRANS_COL   = NUM_COLS - 1;

    // Exact product and exact sum of three products plus the scaled translation
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int SHIFT_BITS = SUM_BITS - FRAC_BITS;

    localparam int ROW_BITS = 2;
    localparam logic [ROW_BITS-1:0] ROW_LAST = 2'd2;
    localparam logic [ROW_BITS-1:0] ROW_NONE = 2'd3;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;

    // Side information that travels with a row through the pipeline
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic                final_joint;
    } row_tag_t;

endpackage

`default_nettype wire

// ===== src/acm_lane.sv =====
`default_nettype none

// One output column: three signed products, then their exact sum plus translation
module acm_lane
    import acm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en_prod,
    input  wire logic  en_sum,
    input  wire word_t a     [NUM_TERMS],
    input  wire word_t s     [NUM_TERMS],
    input  wire word_t trans,
    output sum_t       sum
);

    prod_t prod_reg [NUM_TERMS];
    sum_t  trans_reg;
    sum_t  sum_reg;
    sum_t  sum_next;

    // Product stage; translation scaled to the product's fraction bits
    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                prod_reg[k] <= a[k] * s[k];
            end
            trans_reg <= {{(SUM_BITS - WORD_BITS - FRAC_BITS){trans[WORD_BITS-1]}},
                          trans, {FRAC_BITS{1'b0}}};
        end
    end

    // Sum stage: sign-extend each product and add it to the scaled translation
    always_comb
    begin
        sum_next = trans_reg;
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            sum_next = sum_next + {{(SUM_BITS - PROD_BITS){prod_reg[k][PROD_BITS-1]}},
                                   prod_reg[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// ===== src/acm_merge.sv =====
`default_nettype none

// Gathers the lane sums: drops the fraction bits, clamps each column, ORs the flags
module acm_merge
    import acm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     en,
    input  wire sum_t     sum     [NUM_COLS],
    input  wire row_tag_t tag_in,
    output word_t         result  [NUM_COLS],
    output row_tag_t      tag_out,
    output logic          saturated
);

    word_t    result_reg [NUM_COLS];
    word_t    result_next [NUM_COLS];
    row_tag_t tag_reg;
    logic     sat_reg;
    logic     sat_next;

    logic [SHIFT_BITS-1:0]           shifted [NUM_COLS];
    logic [SHIFT_BITS-WORD_BITS:0]   upper   [NUM_COLS];
    logic [NUM_COLS-1:0]             clamp;

    // Truncate toward minus infinity, then clamp to the signed word range
    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            shifted[c] = sum[c][SUM_BITS-1:FRAC_BITS];
            upper[c]   = shifted[c][SHIFT_BITS-1:WORD_BITS-1];
            clamp[c]   = !((&upper[c]) || !(|upper[c]));
            if (!clamp[c])
            begin
                result_next[c] = shifted[c][WORD_BITS-1:0];
            end
            else if (shifted[c][SHIFT_BITS-1])
            begin
                result_next[c] = {1'b1, {(WORD_BITS-1){1'b0}}};
            end
            else
            begin
                result_next[c] = {1'b0, {(WORD_BITS-1){1'b1}}};
            end
        end
        sat_next = |clamp;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            tag_reg    <= tag_in;
            sat_reg    <= sat_next;
        end
    end

    assign result    = result_reg;
    assign tag_out   = tag_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

// ===== src/affine_3x4_matrix_compose.sv =====
`default_nettype none

// Channel   Dir  tdata                         tuser                          tlast
// s_axis    in   value_0..value_3 (128b)       load_second, row_index         final_joint
// m_axis    out  result_0..result_3 (128b)     out_row, matrix_done, saturated batch_done
//
// One beat per cycle sustained while the output is ready; four lanes, one per
// output column, each with three 32x32 multipliers. An input beat passes through
// the input, product, sum and clamp registers to the output. Load beats write the
// stored matrix at acceptance and give no output. Reset clears only the pipeline
// valid bits; the stored matrix holds garbage until loaded. Output stalls back up
// through the pipeline stage by stage; a bubble anywhere lets input keep flowing.
module affine_3x4_matrix_compose
    import acm_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [NUM_COLS*WORD_BITS-1:0] s_axis_tdata,  // value_0, value_1, value_2, value_3
    input  wire logic [ROW_BITS:0]          s_axis_tuser,  // load_second, row_index
    input  wire logic                       s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [NUM_COLS*WORD_BITS-1:0]   m_axis_tdata,  // result_0, result_1, result_2, result_3
    output logic [ROW_BITS+1:0]             m_axis_tuser,  // out_row, matrix_done, saturated
    output logic                            m_axis_tlast
);

    logic                load_second;
    logic [ROW_BITS-1:0] row_index;
    logic                in_beat;
    logic                row_ok;

    word_t    store_reg [NUM_ROWS][NUM_COLS];

    logic     v1_reg, v2_reg, v3_reg, v4_reg;
    logic     v1_next;
    logic     r1, r2, r3, r4;
    word_t    a_reg [NUM_COLS];
    row_tag_t tag1_reg, tag2_reg, tag3_reg;
    word_t    a_term [NUM_TERMS];
    sum_t     lane_sum [NUM_COLS];
    word_t    result [NUM_COLS];
    row_tag_t tag4;
    logic     saturated;

    assign load_second = s_axis_tuser[0];
    assign row_index   = s_axis_tuser[ROW_BITS:1];
    assign row_ok      = (row_index != ROW_NONE);
    assign in_beat     = s_axis_tvalid && s_axis_tready;

    // Stage readiness: a stage takes new data when empty or when it moves on
    assign r4 = !v4_reg || m_axis_tready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign s_axis_tready = r1;

    assign v1_next = in_beat && !load_second && row_ok;

    // Stored second matrix, one row per load beat
    always_ff @(posedge clk)
    begin
        if (in_beat && load_second && row_ok)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                store_reg[row_index][c] <= s_axis_tdata[c*WORD_BITS +: WORD_BITS];
            end
        end
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= v1_next;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    // Input register and row tags
    always_ff @(posedge clk)
    begin
        if (r1 && v1_next)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                a_reg[c] <= s_axis_tdata[c*WORD_BITS +: WORD_BITS];
            end
            tag1_reg.row         <= row_index;
            tag1_reg.final_joint <= s_axis_tlast;
        end
        if (r2 && v1_reg)
        begin
            tag2_reg <= tag1_reg;
        end
        if (r3 && v2_reg)
        begin
            tag3_reg <= tag2_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            a_term[k] = a_reg[k];
        end
    end

    // One lane per output column
    for (genvar c = 0; c < NUM_COLS; c++)
    begin : g_lane
        word_t col_s [NUM_TERMS];
        word_t trans;

        always_comb
        begin
            for (int k = 0; k < NUM_TERMS; k++)
            begin
                col_s[k] = store_reg[k][c];
            end
        end

        assign trans = (c == TRANS_COL) ? a_reg[TRANS_COL] : '0;

        acm_lane u_lane
        (
            .clk     (clk),
            .en_prod (r2 && v1_reg),
            .en_sum  (r3 && v2_reg),
            .a       (a_term),
            .s       (col_s),
            .trans   (trans),
            .sum     (lane_sum[c])
        );
    end

    acm_merge u_merge
    (
        .clk       (clk),
        .en        (r4 && v3_reg),
        .sum       (lane_sum),
        .tag_in    (tag3_reg),
        .result    (result),
        .tag_out   (tag4),
        .saturated (saturated)
    );

    // Output beat
    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            m_axis_tdata[c*WORD_BITS +: WORD_BITS] = result[c];
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tuser  = {saturated, (tag4.row == ROW_LAST), tag4.row};
    assign m_axis_tlast  = (tag4.row == ROW_LAST) && tag4.final_joint;

endmodule

`default_nettype wire

// ===== bench/tb_affine_3x4_matrix_compose.sv =====
`default_nettype none

module tb_affine_3x4_matrix_compose;
    timeunit 1ns;
    timeprecision 1ps;

    import acm_pkg::*;

    localparam int DATA_W       = NUM_COLS * WORD_BITS;
    localparam int TARGET_ROWS  = 2000;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 16;

    // tuser bit positions
    localparam int S_LOAD_BIT  = 0;
    localparam int M_DONE_BIT  = ROW_BITS;
    localparam int M_SAT_BIT   = ROW_BITS + 1;

    typedef struct packed {
        logic [ROW_BITS-1:0]          row;
        word_t [NUM_COLS-1:0]         col;
        logic                         matrix_done;
        logic                         batch_done;
        logic                         saturated;
    } composed_row_t;

    // Keeps a copy of the stored inverse pose and predicts every composed row
    class compose_checker;
        word_t         inv_pose [NUM_ROWS][NUM_COLS];
        composed_row_t expected_rows [$];
        int            errors;
        int            loads_seen;
        int            transforms_seen;
        int            ignored_seen;
        int            rows_checked;
        int            sat_rows;
        int            batch_ends;

        // Accepted input beat: either store a row or queue its composed row
        function void take_input_row(logic load, logic [ROW_BITS-1:0] row,
                                     logic [DATA_W-1:0] data, logic last);
            word_t                  a [NUM_COLS];
            logic signed [65:0]     acc;
            logic signed [65:0]     x;
            logic signed [65:0]     y;
            logic signed [49:0]     shifted;
            composed_row_t          res;

            for (int c = 0; c < NUM_COLS; c++)
                a[c] = data[c*WORD_BITS +: WORD_BITS];
            if (row == ROW_NONE)
            begin
                ignored_seen++;
                return;
            end
            if (load)
            begin
                for (int c = 0; c < NUM_COLS; c++)
                    inv_pose[row][c] = a[c];
                loads_seen++;
                return;
            end
            transforms_seen++;
            res.row       = row;
            res.saturated = 1'b0;
            for (int c = 0; c < NUM_COLS; c++)
            begin
                acc = '0;
                for (int k = 0; k < NUM_TERMS; k++)
                begin
                    x = a[k];
                    y = inv_pose[k][c];
                    acc = acc + x * y;
                end
                // translation joins at full product scale
                if (c == TRANS_COL)
                begin
                    x = a[TRANS_COL];
                    acc = acc + (x <<< FRAC_BITS);
                end
                shifted = acc >>> FRAC_BITS;
                if (shifted[49:WORD_BITS-1] == '0 || shifted[49:WORD_BITS-1] == '1)
                    res.col[c] = shifted[WORD_BITS-1:0];
                else
                begin
                    res.saturated = 1'b1;
                    res.col[c] = shifted[49] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                             : {1'b0, {(WORD_BITS-1){1'b1}}};
                end
            end
            res.matrix_done = (row == ROW_LAST);
            res.batch_done  = (row == ROW_LAST) && last;
            expected_rows.push_back(res);
        endfunction

        // Accepted output beat against the oldest expected row
        function void check_output_row(composed_row_t got);
            composed_row_t want;

            if (expected_rows.size() == 0)
            begin
                $display("%0t: unexpected output row %0d data %h", $time, got.row, got.col);
                errors++;
                return;
            end
            want = expected_rows.pop_front();
            rows_checked++;
            if (want.saturated)
                sat_rows++;
            if (want.batch_done)
                batch_ends++;
            if (got.row !== want.row)
            begin
                $display("%0t: out_row expected %0d actual %0d", $time, want.row, got.row);
                errors++;
            end
            for (int c = 0; c < NUM_COLS; c++)
                if (got.col[c] !== want.col[c])
                begin
                    $display("%0t: row %0d result_%0d expected %h actual %h",
                             $time, want.row, c, want.col[c], got.col[c]);
                    errors++;
                end
            if (got.matrix_done !== want.matrix_done)
            begin
                $display("%0t: matrix_done expected %b actual %b",
                         $time, want.matrix_done, got.matrix_done);
                errors++;
            end
            if (got.batch_done !== want.batch_done)
            begin
                $display("%0t: batch_done expected %b actual %b",
                         $time, want.batch_done, got.batch_done);
                errors++;
            end
            if (got.saturated !== want.saturated)
            begin
                $display("%0t: saturated expected %b actual %b",
                         $time, want.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata;   // value_0, value_1, value_2, value_3
    logic [ROW_BITS:0]     s_axis_tuser;   // load_second, row_index
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_W-1:0]     m_axis_tdata;   // result_0, result_1, result_2, result_3
    logic [ROW_BITS+1:0]   m_axis_tuser;   // out_row, matrix_done, saturated
    logic                  m_axis_tlast;

    compose_checker composer;
    int             rows_sent;
    int             quiet_cycles;

    affine_3x4_matrix_compose dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;

        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Mix of small Q16.16 values, full-range words and corner words
    function automatic word_t rand_word();
        int r;

        r = $urandom_range(0, 9);
        if (r < 5)
            return word_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        else if (r < 8)
            return word_t'($urandom());
        else if (r < 9)
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0001_0000;
            endcase
        else
            return word_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endfunction

    function automatic logic [DATA_W-1:0] pack_row(word_t v0, word_t v1, word_t v2, word_t v3);
        return {v3, v2, v1, v0};
    endfunction

    function automatic logic [DATA_W-1:0] rand_row();
        return pack_row(rand_word(), rand_word(), rand_word(), rand_word());
    endfunction

    // Present one beat after an optional gap and hold it until taken
    task automatic send_row(input logic load, input logic [ROW_BITS-1:0] row,
                            input logic [DATA_W-1:0] data, input logic last,
                            input bit no_gap);
        int gap;

        gap = no_gap ? 0 : idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= {row, load};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (row != ROW_NONE)
            rows_sent++;
    endtask

    // Receiver: ready runs broken by stalls, some runs very long
    initial
    begin
        int  run;
        bit  rdy;

        m_axis_tready = 1'b0;
        run = 0;
        rdy = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (run == 0)
            begin
                rdy = !rdy;
                if (rdy)
                    run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
                else
                    run = idle_len() + 1;
                m_axis_tready <= rdy;
            end
            run--;
        end
    end

    // Beat monitor on both sides plus stall watchdog
    always @(posedge clk)
    begin
        composed_row_t got;
        bit            moved;

        if (rst_n)
        begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                composer.take_input_row(s_axis_tuser[S_LOAD_BIT], s_axis_tuser[ROW_BITS:1],
                                        s_axis_tdata, s_axis_tlast);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.row         = m_axis_tuser[ROW_BITS-1:0];
                got.matrix_done = m_axis_tuser[M_DONE_BIT];
                got.saturated   = m_axis_tuser[M_SAT_BIT];
                got.batch_done  = m_axis_tlast;
                for (int c = 0; c < NUM_COLS; c++)
                    got.col[c] = m_axis_tdata[c*WORD_BITS +: WORD_BITS];
                composer.check_output_row(got);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        bit last;
        bit burst;
        int n;

        composer      = new();
        rows_sent     = 0;
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // near-identity pose with odd translations
        send_row(1'b1, 2'd0, pack_row(32'h0001_0000, 0, 0, 32'h0001_8000), 1'b0, 1'b0);
        send_row(1'b1, 2'd1, pack_row(0, 32'h0001_0000, 0, 32'hFFFF_8000), 1'b0, 1'b0);
        send_row(1'b1, 2'd2, pack_row(0, 0, 32'h0001_0000, 32'h7FFF_FFFF), 1'b0, 1'b0);
        send_row(1'b0, 2'd0, pack_row(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF),
                 1'b0, 1'b0);
        // final flag on a middle row must not end the batch
        send_row(1'b0, 2'd1, pack_row(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                 32'h7FFF_FFFF), 1'b1, 1'b0);
        send_row(1'b0, ROW_LAST, pack_row(0, 0, 0, 0), 1'b1, 1'b0);

        // row three is dropped for load and transform
        send_row(1'b1, ROW_NONE, {DATA_W{1'b1}}, 1'b0, 1'b0);
        send_row(1'b0, ROW_NONE, rand_row(), 1'b1, 1'b0);

        // extreme pose; final flag on loads has no effect
        send_row(1'b1, 2'd0, pack_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000), 1'b1, 1'b0);
        send_row(1'b1, 2'd1, pack_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF), 1'b1, 1'b0);
        send_row(1'b1, 2'd2, pack_row(32'h0000_8000, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h0000_0001), 1'b0, 1'b0);
        // positive clamp, negative clamp, truncation toward minus infinity
        send_row(1'b0, 2'd0, pack_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000), 1'b0, 1'b1);
        send_row(1'b0, 2'd1, pack_row(32'h7FFF_FFFF, 0, 0, 32'h8000_0000), 1'b0, 1'b1);
        send_row(1'b0, ROW_LAST, pack_row(0, 0, 32'hFFFF_FFFF, 0), 1'b0, 1'b1);
        send_row(1'b0, ROW_LAST, pack_row(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 0),
                 1'b1, 1'b1);
        send_row(1'b0, 2'd0, {DATA_W{1'b1}}, 1'b0, 1'b0);
        send_row(1'b0, 2'd1, {DATA_W{1'b0}}, 1'b0, 1'b0);

        // random joints, with some stray and malformed beats mixed in
        rows_sent = 0;
        while (rows_sent < TARGET_ROWS)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                last  = ($urandom_range(0, 5) == 0);
                burst = ($urandom_range(0, 3) == 0);
                for (int r = 0; r < NUM_ROWS; r++)
                    send_row(1'b1, r[ROW_BITS-1:0], rand_row(), last, burst);
                for (int r = 0; r < NUM_ROWS; r++)
                    send_row(1'b0, ($urandom_range(0, 4) == 0)
                                       ? ROW_BITS'($urandom_range(0, 2))
                                       : r[ROW_BITS-1:0],
                             rand_row(), last, burst);
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_row(1'($urandom_range(0, 1)), ROW_BITS'($urandom_range(0, 3)),
                             rand_row(), 1'($urandom_range(0, 1)), 1'b0);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain the pipeline
        while (composer.expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d pose loads, %0d transforms, %0d dropped row-three beats.",
                 composer.loads_seen, composer.transforms_seen, composer.ignored_seen);
        $display("Checked %0d composed rows: %0d saturated, %0d batch ends.",
                 composer.rows_checked, composer.sat_rows, composer.batch_ends);
        if (composer.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ===== affine_3x4_matrix_compose.f =====
src/acm_pkg.sv
src/acm_lane.sv
src/acm_merge.sv
src/affine_3x4_matrix_compose.sv
bench/tb_affine_3x4_matrix_compose.sv
